@@ design/pqsi_pkg.sv @@
// Package for the priority queue unit: sizes, codes, state type and the
// structs passed between the pointer file and the controller. No dependencies.
package pqsi_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TAG_BITS    = 16;

  localparam int LEVEL_W     = 2;
  localparam int NUM_LEVELS  = 1 << LEVEL_W;
  localparam int AGE_W       = 8;
  localparam int TAG_W       = 16;
  localparam int OCC_W       = 5;

  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W      = LEVEL_W + PTR_W;
  localparam int RAM_DEPTH   = NUM_LEVELS << PTR_W;
  localparam int STORE_TAG_W = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
  localparam int ENTRY_W     = AGE_W + STORE_TAG_W;

  localparam logic [LEVEL_W-1:0] LEVEL_RED    = 2'd3;
  localparam logic [LEVEL_W-1:0] LEVEL_YELLOW = 2'd2;
  localparam logic [LEVEL_W-1:0] LEVEL_GREEN  = 2'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_NONE   = 2'd0;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  typedef enum logic [1:0] {
    ST_INS_OK    = 2'd0,
    ST_INS_FULL  = 2'd1,
    ST_POP_OK    = 2'd2,
    ST_POP_EMPTY = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_READ
  } ctrl_state_t;

  // pointer file view of the queue
  typedef struct packed {
    logic               empty;
    logic               full;
    logic [LEVEL_W-1:0] pop_level;
    logic [ADDR_W-1:0]  head_addr;
    logic [ADDR_W-1:0]  tail_addr;
    logic [CNT_W-1:0]   total;
  } occ_t;

  // bookkeeping update from the controller
  typedef struct packed {
    logic               push;
    logic               pop;
    logic [LEVEL_W-1:0] push_level;
  } upd_t;

endpackage

@@ design/pqsi_cmd_if.sv @@
// Request channel into the priority queue unit.
// Depends on pqsi_pkg for field widths.
interface pqsi_cmd_if import pqsi_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               command;
  logic [LEVEL_W-1:0] level;
  logic [AGE_W-1:0]   patient_age;
  logic [TAG_W-1:0]   record_tag;

  modport source (output valid, command, level, patient_age, record_tag, input ready);
  modport sink   (input valid, command, level, patient_age, record_tag, output ready);
  modport monitor (input valid, ready, command, level, patient_age, record_tag);
endinterface

@@ design/pqsi_res_if.sv @@
// Result channel out of the priority queue unit.
// Depends on pqsi_pkg for field widths.
interface pqsi_res_if import pqsi_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [LEVEL_W-1:0] out_level;
  logic [AGE_W-1:0]   out_age;
  logic [TAG_W-1:0]   out_tag;
  logic [OCC_W-1:0]   occupancy;

  modport source (output valid, status, out_level, out_age, out_tag, occupancy, input ready);
  modport sink   (input valid, status, out_level, out_age, out_tag, occupancy, output ready);
  modport monitor (input valid, ready, status, out_level, out_age, out_tag, occupancy);
endinterface

@@ design/priority_queue_sorted_insert_unit.sv @@
// Priority queue unit, top level. Entries sit in one RAM split into one
// FIFO region per level; head and tail pointers select the entry to read or write.
// Depends on pqsi_pkg, pqsi_cmd_if, pqsi_res_if, pqsi_ram, pqsi_level_ptrs, pqsi_ctrl.
//
// Bounded priority queue of QUEUE_DEPTH entries. Each request is an insert
// or a pop and gives exactly one result carrying a status and the count of
// stored entries after the request. Higher levels leave first, equal levels
// in arrival order; a full queue refuses inserts. An insert or a pop on an
// empty queue is answered from the result register; a pop that returns an
// entry first reads the entry RAM, whose read data is registered, and no new
// request is taken during that read. A request is taken while the previous result
// is being delivered. No clearing pass: after reset the block is ready at once.
module priority_queue_sorted_insert_unit import pqsi_pkg::*; (
  input logic        clk,
  input logic        rst,
  pqsi_cmd_if.sink   cmd,
  pqsi_res_if.source res
);

  occ_t               occ;
  upd_t               upd;
  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  pqsi_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pqsi_level_ptrs u_ptrs (
    .clk       (clk),
    .rst       (rst),
    .upd       (upd),
    .ins_level (cmd.level),
    .occ       (occ)
  );

  pqsi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .res       (res),
    .occ       (occ),
    .upd       (upd),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

endmodule

@@ design/pqsi_ram.sv @@
// Generic single write, single read port RAM with registered read data.
// No dependencies.
module pqsi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/pqsi_level_ptrs.sv @@
// Per-level FIFO pointers and counts over the shared entry RAM.
// Depends on pqsi_pkg.
module pqsi_level_ptrs import pqsi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  upd_t               upd,
  input  logic [LEVEL_W-1:0] ins_level,
  output occ_t               occ
);

  logic [PTR_W-1:0] head [NUM_LEVELS];
  logic [PTR_W-1:0] tail [NUM_LEVELS];
  logic [CNT_W-1:0] lvl_cnt [NUM_LEVELS];
  logic [CNT_W-1:0] total;
  logic [LEVEL_W-1:0] sel;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // highest non-empty level leaves first
  always_comb begin
    if (lvl_cnt[LEVEL_RED] != '0) begin
      sel = LEVEL_RED;
    end else if (lvl_cnt[LEVEL_YELLOW] != '0) begin
      sel = LEVEL_YELLOW;
    end else if (lvl_cnt[LEVEL_GREEN] != '0) begin
      sel = LEVEL_GREEN;
    end else begin
      sel = LEVEL_NONE;
    end
  end

  assign occ.empty     = (total == '0);
  assign occ.full      = (total == CNT_W'(QUEUE_DEPTH));
  assign occ.pop_level = sel;
  assign occ.head_addr = {sel, head[sel]};
  assign occ.tail_addr = {ins_level, tail[ins_level]};
  assign occ.total     = total;

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head[i]    <= '0;
        tail[i]    <= '0;
        lvl_cnt[i] <= '0;
      end
    end else begin
      if (upd.push) begin
        tail[upd.push_level]    <= ptr_inc(tail[upd.push_level]);
        lvl_cnt[upd.push_level] <= lvl_cnt[upd.push_level] + 1'b1;
        total                   <= total + 1'b1;
      end else if (upd.pop) begin
        head[sel]    <= ptr_inc(head[sel]);
        lvl_cnt[sel] <= lvl_cnt[sel] - 1'b1;
        total        <= total - 1'b1;
      end
    end
  end

endmodule

@@ design/pqsi_ctrl.sv @@
// Request sequencer and result register of the priority queue unit.
// Depends on pqsi_pkg; drives the entry RAM and the pointer file.
module pqsi_ctrl import pqsi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  pqsi_cmd_if.sink           cmd,
  pqsi_res_if.source         res,
  input  occ_t               occ,
  output upd_t               upd,
  output logic               ram_we,
  output logic [ADDR_W-1:0]  ram_waddr,
  output logic [ENTRY_W-1:0] ram_wdata,
  output logic               ram_re,
  output logic [ADDR_W-1:0]  ram_raddr,
  input  logic [ENTRY_W-1:0] ram_rdata
);

  ctrl_state_t state, state_next;

  logic               out_valid;
  status_t            out_status;
  logic [LEVEL_W-1:0] out_level;
  logic [AGE_W-1:0]   out_age;
  logic [TAG_W-1:0]   out_tag;
  logic [OCC_W-1:0]   out_occ;
  logic [LEVEL_W-1:0] pend_level;

  logic accept, is_ins, is_pop, out_free;

  assign out_free = !out_valid || res.ready;
  assign is_ins   = (cmd.command == CMD_INSERT);
  assign is_pop   = (cmd.command == CMD_POP);
  assign accept   = cmd.valid && cmd.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && is_pop && !occ.empty) begin
          state_next = S_READ;
        end
      end
      S_READ: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.ready      = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    upd.push       = 1'b0;
    upd.pop        = 1'b0;
    upd.push_level = cmd.level;
    unique case (state)
      S_IDLE: begin
        cmd.ready = out_free;
        ram_we    = accept && is_ins && !occ.full;
        ram_re    = accept && is_pop && !occ.empty;
        upd.push  = ram_we;
        upd.pop   = ram_re;
      end
      S_READ: ;
      default: ;
    endcase
  end

  assign ram_waddr = occ.tail_addr;
  assign ram_wdata = {cmd.patient_age, STORE_TAG_W'(cmd.record_tag)};
  assign ram_raddr = occ.head_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_READ) begin
        out_valid <= 1'b1;
      end else if (accept && !(is_pop && !occ.empty)) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      out_status <= ST_POP_OK;
      out_level  <= pend_level;
      out_age    <= ram_rdata[ENTRY_W-1 -: AGE_W];
      out_tag    <= TAG_W'(ram_rdata[STORE_TAG_W-1:0]);
      out_occ    <= OCC_W'(occ.total);
    end else if (accept) begin
      out_level  <= '0;
      out_age    <= '0;
      out_tag    <= '0;
      pend_level <= occ.pop_level;
      if (is_ins) begin
        out_status <= occ.full ? ST_INS_FULL : ST_INS_OK;
        out_occ    <= occ.full ? OCC_W'(occ.total) : OCC_W'(occ.total + 1'b1);
      end else begin
        out_status <= ST_POP_EMPTY;
        out_occ    <= OCC_W'(occ.total);
      end
    end
  end

  assign res.valid     = out_valid;
  assign res.status    = out_status;
  assign res.out_level = out_level;
  assign res.out_age   = out_age;
  assign res.out_tag   = out_tag;
  assign res.occupancy = out_occ;

endmodule

@@ design/pqsi_checker.sv @@
// Port-level checks for the priority queue unit, bound to the top level.
// Depends on pqsi_pkg, pqsi_res_if.
module pqsi_checker import pqsi_pkg::*; (
  input logic        clk,
  input logic        rst,
  pqsi_res_if.source res
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !res.valid)
    else $error("result valid after reset");

  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.status == ST_POP_EMPTY) |-> res.occupancy == '0)
    else $error("empty pop with non-zero occupancy");

  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.status == ST_INS_FULL) |-> res.occupancy == OCC_W'(QUEUE_DEPTH))
    else $error("refused insert while not full");

  a_no_payload: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.status != ST_POP_OK) |->
      (res.out_level == '0 && res.out_age == '0 && res.out_tag == '0))
    else $error("payload on a result without an entry");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready) |=> (res.valid && $stable(res.status) &&
      $stable(res.out_tag) && $stable(res.occupancy)))
    else $error("stalled result changed");

endmodule

bind priority_queue_sorted_insert_unit pqsi_checker u_pqsi_checker (
  .clk (clk),
  .rst (rst),
  .res (res)
);

@@ tb/sv/tb_top.sv @@
// Testbench for priority_queue_sorted_insert_unit: a sorted-queue predictor checks
// every result field; directed, random and back-pressure requests are applied.
// Depends on pqsi_pkg, pqsi_cmd_if, pqsi_res_if and the unit itself.
module tb_top;
  import pqsi_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 10;
  localparam int STALL_CYCLES = 300;
  localparam int BURST_LEN    = 40;

  localparam logic [TAG_W-1:0] TAG_KEEP = {TAG_W{1'b1}} >> (TAG_W - STORE_TAG_W);

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [AGE_W-1:0]   age;
    logic [TAG_W-1:0]   tag;
  } slot_t;

  typedef struct packed {
    status_t            status;
    logic [LEVEL_W-1:0] level;
    logic [AGE_W-1:0]   age;
    logic [TAG_W-1:0]   tag;
    logic [OCC_W-1:0]   occupancy;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pqsi_cmd_if cmd_ch ();
  pqsi_res_if res_ch ();

  priority_queue_sorted_insert_unit uut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  always #1 clk = ~clk;

  slot_t       ranked_slots[$];
  result_t     pending_results[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stall_left    = 0;
  int unsigned error_count   = 0;
  int unsigned cycle_count   = 0;

  function automatic result_t predict_result(input logic c, input logic [LEVEL_W-1:0] l,
                                             input logic [AGE_W-1:0] a,
                                             input logic [TAG_W-1:0] t);
    result_t r;
    slot_t   s;
    int      pos;
    r = '0;
    if (c == CMD_INSERT) begin
      if (ranked_slots.size() >= QUEUE_DEPTH) begin
        r.status = ST_INS_FULL;
      end else begin
        // behind every entry of equal or higher level
        pos = 0;
        while (pos < ranked_slots.size() && ranked_slots[pos].level >= l) pos++;
        s.level = l;
        s.age   = a;
        s.tag   = t & TAG_KEEP;
        ranked_slots.insert(pos, s);
        r.status = ST_INS_OK;
      end
    end else if (ranked_slots.size() == 0) begin
      r.status = ST_POP_EMPTY;
    end else begin
      s = ranked_slots.pop_front();
      r.status = ST_POP_OK;
      r.level  = s.level;
      r.age    = s.age;
      r.tag    = s.tag;
    end
    r.occupancy = OCC_W'(ranked_slots.size());
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst) begin
      if (cmd_ch.valid && cmd_ch.ready)
        pending_results.push_back(predict_result(cmd_ch.command, cmd_ch.level,
                                                 cmd_ch.patient_age, cmd_ch.record_tag));
      if (res_ch.valid && res_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("result with no request outstanding");
          error_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", 32'(want.status), 32'(res_ch.status));
          check_field("out_level", 32'(want.level), 32'(res_ch.out_level));
          check_field("out_age", 32'(want.age), 32'(res_ch.out_age));
          check_field("out_tag", 32'(want.tag), 32'(res_ch.out_tag));
          check_field("occupancy", 32'(want.occupancy), 32'(res_ch.occupancy));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("priority_queue_sorted_insert_unit: mismatch");
      $finish;
    end
  end

  // result side: long hold-off first, otherwise random idling
  always @(negedge clk) begin
    if (stall_left != 0) begin
      res_ch.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_request(input logic c, input logic [LEVEL_W-1:0] l,
                              input logic [AGE_W-1:0] a, input logic [TAG_W-1:0] t);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.command     <= c;
    cmd_ch.level       <= l;
    cmd_ch.patient_age <= a;
    cmd_ch.record_tag  <= t;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
  endtask

  task automatic send_insert(input logic [LEVEL_W-1:0] l, input logic [AGE_W-1:0] a,
                             input logic [TAG_W-1:0] t);
    send_request(CMD_INSERT, l, a, t);
  endtask

  // payload of a pop is ignored; keep it random
  task automatic send_pop();
    send_request(CMD_POP, LEVEL_W'($urandom_range(3)), AGE_W'($urandom_range(255)),
                 TAG_W'($urandom_range(65535)));
  endtask

  task automatic send_random_request(input int unsigned insert_pct);
    logic [LEVEL_W-1:0] l;
    l = ($urandom_range(9) == 0) ? LEVEL_NONE : LEVEL_W'($urandom_range(3, 1));
    if ($urandom_range(99) < insert_pct)
      send_insert(l, AGE_W'($urandom_range(255)), TAG_W'($urandom_range(65535)));
    else
      send_pop();
  endtask

  task automatic test_level_order();
    send_pop();
    send_insert(LEVEL_GREEN, 8'h00, 16'h0000);
    send_insert(LEVEL_RED, 8'hFF, 16'hFFFF);
    send_insert(LEVEL_NONE, 8'h5A, 16'hA5A5);
    send_insert(LEVEL_YELLOW, 8'h01, 16'h8001);
    send_insert(LEVEL_RED, 8'h80, 16'h7FFE);
    send_insert(LEVEL_GREEN, 8'h7F, 16'h0001);
  endtask

  task automatic test_full_queue();
    repeat (QUEUE_DEPTH - 6) send_random_request(100);
    send_insert(LEVEL_RED, 8'hC3, 16'h3C3C);
    repeat (5) send_pop();
  endtask

  task automatic test_random_traffic(input int n, input int unsigned s_pct,
                                     input int unsigned r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    // alternate filling and draining bursts so full and empty are both reached
    for (int i = 0; i < n; i++)
      send_random_request(((i / BURST_LEN) % 2 == 0) ? 75 : 25);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_left    = STALL_CYCLES;
    repeat (40) send_random_request(60);
  endtask

  initial begin
    cmd_ch.valid       = 1'b0;
    cmd_ch.command     = CMD_INSERT;
    cmd_ch.level       = LEVEL_NONE;
    cmd_ch.patient_age = '0;
    cmd_ch.record_tag  = '0;
    res_ch.ready       = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_level_order();
    test_full_queue();
    test_random_traffic(340, 35, 63);
    test_random_traffic(340, 63, 35);
    test_random_traffic(320, 0, 0);
    test_backpressure();

    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("priority_queue_sorted_insert_unit: match");
    else
      $display("priority_queue_sorted_insert_unit: mismatch");
    $finish;
  end

endmodule

@@ sim.f @@
design/pqsi_pkg.sv
design/pqsi_cmd_if.sv
design/pqsi_res_if.sv
design/pqsi_ram.sv
design/pqsi_level_ptrs.sv
design/pqsi_ctrl.sv
design/priority_queue_sorted_insert_unit.sv
design/pqsi_checker.sv
tb/sv/tb_top.sv
